// File: hw/rtl/lptsc_pkg.sv
`timescale 1ns / 1ps

package lptsc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned LEN_W      = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVCC_MODE          = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_FIELD_BYTES = 1'd1;

  // legal prefix sizes
  localparam logic [2:0] LFB_ONE  = 3'd1;
  localparam logic [2:0] LFB_TWO  = 3'd2;
  localparam logic [2:0] LFB_FOUR = 3'd4;

  localparam logic [2:0] LFB_RESET = LFB_FOUR;

  // start code 00 00 00 01, indexed by position
  localparam logic [1:0] SC_LAST_IDX  = 2'd3;
  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  // one or four results produced by one input transaction
  typedef struct packed {
    logic       sc;      // four-byte start code instead of a single result
    logic [7:0] data;    // byte of a single result
    logic       vld;     // byte_valid of a single result
    logic       eos;     // end marker on the final result
    logic       status;  // corrupt flag on the final result
  } burst_t;

endpackage

// File: hw/rtl/lptsc_parse.sv
`timescale 1ns / 1ps

module lptsc_parse (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lptsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lptsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              item_go,
  input  logic [7:0]                        item_byte,
  input  logic                              item_last,
  output logic                              burst_push,
  output lptsc_pkg::burst_t                 burst
);
  import lptsc_pkg::*;

  logic             avcc_mode_r;
  logic [2:0]       lfb_r;
  logic             in_payload_r, in_payload_nxt;
  logic [LEN_W-1:0] length_accum_r, length_accum_nxt;
  logic [1:0]       lbs_r, lbs_nxt;
  logic [LEN_W-1:0] payload_left_r, payload_left_nxt;
  logic             sample_error_r, sample_error_nxt;

  logic             lfb_ok;
  logic             emit;
  logic [LEN_W-1:0] accum_shift;

  assign accum_shift = {length_accum_r[LEN_W-9:0], item_byte};

  always_comb begin
    lfb_ok           = lfb_r inside {LFB_ONE, LFB_TWO, LFB_FOUR};
    in_payload_nxt   = in_payload_r;
    length_accum_nxt = length_accum_r;
    lbs_nxt          = lbs_r;
    payload_left_nxt = payload_left_r;
    sample_error_nxt = sample_error_r;
    emit             = 1'b0;
    burst            = '0;

    if (!avcc_mode_r) begin
      burst.data = item_byte;
      burst.vld  = 1'b1;
      emit       = 1'b1;
    end else if (!lfb_ok) begin
      sample_error_nxt = 1'b1;
    end else if (sample_error_r) begin
      // corrupt sample: swallow bytes until the end
    end else if (in_payload_r) begin
      burst.data       = item_byte;
      burst.vld        = 1'b1;
      emit             = 1'b1;
      payload_left_nxt = payload_left_r - LEN_W'(1);
      if (payload_left_r == LEN_W'(1)) begin
        in_payload_nxt = 1'b0;
      end
    end else begin
      if (({1'b0, lbs_r} + 3'd1) == lfb_r) begin
        burst.sc         = 1'b1;
        burst.vld        = 1'b1;
        emit             = 1'b1;
        payload_left_nxt = accum_shift;
        in_payload_nxt   = (accum_shift != '0);
        length_accum_nxt = '0;
        lbs_nxt          = '0;
      end else begin
        length_accum_nxt = accum_shift;
        lbs_nxt          = lbs_r + 2'd1;
      end
    end

    if (item_last) begin
      burst.eos        = 1'b1;
      burst.status     = sample_error_nxt | in_payload_nxt | (lbs_nxt != '0);
      emit             = 1'b1;
      in_payload_nxt   = 1'b0;
      length_accum_nxt = '0;
      lbs_nxt          = '0;
      payload_left_nxt = '0;
      sample_error_nxt = 1'b0;
    end
  end

  assign burst_push = item_go & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avcc_mode_r    <= 1'b1;
      lfb_r          <= LFB_RESET;
      in_payload_r   <= 1'b0;
      length_accum_r <= '0;
      lbs_r          <= '0;
      payload_left_r <= '0;
      sample_error_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AVCC_MODE:          avcc_mode_r <= cfg_wdata[0];
          REG_LENGTH_FIELD_BYTES: lfb_r       <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (item_go) begin
        in_payload_r   <= in_payload_nxt;
        length_accum_r <= length_accum_nxt;
        lbs_r          <= lbs_nxt;
        payload_left_r <= payload_left_nxt;
        sample_error_r <= sample_error_nxt;
      end
    end
  end

  a_payload_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (payload_left_r != '0))
    else $error("payload phase with nothing left to pass");

  a_payload_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_payload_r |-> (payload_left_r == '0))
    else $error("payload count left over outside payload phase");

  a_prefix_not_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (lbs_r != '0) |-> !in_payload_r)
    else $error("length prefix in progress during payload");

endmodule

// File: hw/rtl/lptsc_burst.sv
`timescale 1ns / 1ps

module lptsc_burst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              burst_push,
  input  lptsc_pkg::burst_t burst,
  output logic              burst_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_end_of_sample,
  output logic              out_status
);
  import lptsc_pkg::*;

  logic   busy_r;
  burst_t burst_r;
  logic [1:0] idx_r;
  logic   take;
  logic   final_res;

  assign take        = busy_r & ~out_stall;
  assign final_res   = ~burst_r.sc | (idx_r == SC_LAST_IDX);
  assign burst_ready = ~busy_r | (take & final_res);

  assign out_valid         = busy_r;
  assign out_byte          = burst_r.sc ? ((idx_r == SC_LAST_IDX) ? SC_LAST_BYTE : SC_ZERO_BYTE)
                                        : burst_r.data;
  assign out_byte_valid    = burst_r.vld;
  assign out_end_of_sample = burst_r.eos & final_res;
  assign out_status        = burst_r.status & final_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (burst_ready) begin
      busy_r <= burst_push;
      idx_r  <= '0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_ready && burst_push) begin
      burst_r <= burst;
    end
  end

  a_idx_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !burst_r.sc) |-> (idx_r == '0))
    else $error("single result burst advanced its index");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_stall) |=> (busy_r && $stable(idx_r)))
    else $error("start code position moved while stalled");

  a_empty_only_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_end_of_sample)
    else $error("byte-less result without end marker");

endmodule

// File: hw/rtl/length_prefix_to_start_code_unit.sv
`timescale 1ns / 1ps

// Length-prefixed (AVCC) to start-code (Annex B) rewriter.
// Input: one sample byte per transaction (in_valid/in_stall), the final byte
// marked by in_last_of_sample. Output: one result per transaction
// (out_valid/out_stall) carrying a byte, its byte_valid flag, and on the
// final result of a sample the end marker with status (0 ok, 1 corrupt).
// Config: cfg_we writes avcc_mode (index 0) or length_field_bytes (index 1);
// only write while the block is idle.
// Path: a byte, once accepted, passes the input register and then the burst
// register before its result leaves. Throughput is one byte per cycle while
// out_stall stays low; a byte that completes a length prefix yields the four
// start-code bytes, which leave in turn while input is held off.
// Reset (rst_n low, synchronous): passthrough off, 4-byte prefixes, parser
// back to expecting a length, all registers empty.
// A stalled output holds its result; in_stall rises once the input register
// holds a byte the burst stage cannot yet take.
module length_prefix_to_start_code_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lptsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lptsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last_of_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_byte_valid,
  output logic                             out_end_of_sample,
  output logic                             out_status
);
  import lptsc_pkg::*;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic   burst_ready;
  logic   burst_push;
  burst_t burst;
  logic   item_go;

  // the held byte is parsed as soon as the burst stage can take its results
  assign item_go  = in_v_r & burst_ready;
  assign in_stall = in_v_r & ~burst_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last_of_sample;
    end
  end

  lptsc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_go    (item_go),
    .item_byte  (in_byte_r),
    .item_last  (in_last_r),
    .burst_push (burst_push),
    .burst      (burst)
  );

  lptsc_burst u_burst (
    .clk               (clk),
    .rst_n             (rst_n),
    .burst_push        (burst_push),
    .burst             (burst),
    .burst_ready       (burst_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_sample (out_end_of_sample),
    .out_status        (out_status)
  );

endmodule

// File: verif/length_prefix_to_start_code_unit_test.sv
`timescale 1ns / 1ps

// Bench for the AVCC to Annex B rewriter. Sample bytes go in one transaction
// at a time; a behavioural copy of the rewriter runs alongside and queues the
// results it expects. The monitor pops that queue for every result transaction
// and compares it field by field.
module length_prefix_to_start_code_unit_test;
  import lptsc_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS   = 110;    // random bytes in legal modes
  localparam int CYCLE_LIMIT    = 400000; // far beyond the slowest legal run
  localparam int SETTLE_CYCLES  = 8;      // settling time before a register write
  localparam int TAIL_CYCLES    = 12;
  localparam int SQUEEZE_AFTER  = 60;     // input transactions before the hold-off
  localparam int SQUEEZE_CYCLES = 120;

  // Register values the bench writes by name
  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_AVCC = 3'd1;
  localparam logic [2:0] LFB_NONE  = 3'd0;  // illegal prefix sizes
  localparam logic [2:0] LFB_ODD   = 3'd3;
  localparam logic [2:0] LFB_TOP   = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_vld;
    logic       eos;
    logic       corrupt;
  } out_rec_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;
  // Where a row's expectation comes from: the running model, typed in, or none at all
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [2:0]             reg_val;
    logic [7:0]             data;
    logic                   last;
    row_check_t             chk;
    out_rec_t               want;
  } plan_row_t;

  localparam out_rec_t NO_REC = '0;
  localparam int NUM_ROWS = 33;

  // Directed opening. Starts from the reset settings: rewriting, 4-byte prefixes.
  localparam plan_row_t PLAN [NUM_ROWS] = '{
    // one-byte NAL after reset; the first three prefix bytes emit nothing
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h01, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'hFF, 1'b1, CHK_ONE,   '{8'hFF, 1'b1, 1'b1, 1'b0}},
    // zero-length NAL, then a length field cut short by the end of sample
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b1, CHK_ONE,   '{8'h00, 1'b0, 1'b1, 1'b1}},
    // 1-byte prefix, NAL overruns the sample
    '{ROW_REG,  REG_LENGTH_FIELD_BYTES, LFB_ONE, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h03, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h80, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h7F, 1'b1, CHK_ONE,   '{8'h7F, 1'b1, 1'b1, 1'b1}},
    // 2-byte prefix at its largest length
    '{ROW_REG,  REG_LENGTH_FIELD_BYTES, LFB_TWO, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'hFF, 1'b0, CHK_NONE,  NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'hFF, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h01, 1'b1, CHK_ONE,   '{8'h01, 1'b1, 1'b1, 1'b1}},
    // illegal prefix sizes: bytes dropped, sample flagged corrupt
    '{ROW_REG,  REG_LENGTH_FIELD_BYTES, LFB_NONE, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h34, 1'b1, CHK_ONE,   '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{ROW_REG,  REG_LENGTH_FIELD_BYTES, LFB_TOP, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h00, 1'b1, CHK_ONE,   '{8'h00, 1'b0, 1'b1, 1'b1}},
    // mode flipped mid-NAL: parser state must survive the passthrough bytes
    '{ROW_REG,  REG_LENGTH_FIELD_BYTES, LFB_ONE, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h02, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h11, 1'b0, CHK_MODEL, NO_REC},
    '{ROW_REG,  REG_AVCC_MODE, MODE_PASS, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'hFF, 1'b0, CHK_ONE,   '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_REG,  REG_AVCC_MODE, MODE_AVCC, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h22, 1'b1, CHK_ONE,   '{8'h22, 1'b1, 1'b1, 1'b0}},
    // passthrough ignores an illegal prefix size
    '{ROW_REG,  REG_LENGTH_FIELD_BYTES, LFB_ODD, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_REG,  REG_AVCC_MODE, MODE_PASS, 8'h00, 1'b0, CHK_NONE, NO_REC},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'hA5, 1'b0, CHK_ONE,   '{8'hA5, 1'b1, 1'b0, 1'b0}},
    '{ROW_BYTE, REG_AVCC_MODE, 3'd0, 8'h5A, 1'b1, CHK_ONE,   '{8'h5A, 1'b1, 1'b1, 1'b0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_byte;
  logic                  in_last_of_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_byte;
  logic                  out_byte_valid;
  logic                  out_end_of_sample;
  logic                  out_status;

  length_prefix_to_start_code_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_last_of_sample (in_last_of_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_sample (out_end_of_sample),
    .out_status        (out_status)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Results still owed by the block, oldest first
  out_rec_t annexb_due [$];
  int       err_count   = 0;
  int       bytes_taken = 0;  // accepted input transactions
  int       fed_items   = 0;  // random bytes sent in a legal mode
  bit       tx_calm     = 1'b0;
  bit       squeeze_done = 1'b0;

  // Rewriter state as the bench sees it
  logic [2:0]  rw_mode;
  logic [2:0]  rw_pfx;
  logic        rw_in_nal;
  logic [31:0] rw_len_acc;
  logic [1:0]  rw_len_seen;
  logic [31:0] rw_nal_left;
  logic        rw_bad;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic bit lfb_legal(input logic [2:0] v);
    return (v == LFB_ONE) || (v == LFB_TWO) || (v == LFB_FOUR);
  endfunction

  // Mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // One sample byte through the rewriter; keep=0 only advances the state
  task automatic rewrite_byte(input logic [7:0] b, input logic last, input bit keep);
    out_rec_t res [4];
    int       n;
    logic     corrupt;
    n = 0;
    if (rw_mode == MODE_PASS) begin
      res[n] = '{b, 1'b1, 1'b0, 1'b0};
      n++;
    end else if (!lfb_legal(rw_pfx)) begin
      rw_bad = 1'b1;
    end else if (rw_bad) begin
      // sample already corrupt: bytes dropped
    end else if (rw_in_nal) begin
      res[n] = '{b, 1'b1, 1'b0, 1'b0};
      n++;
      rw_nal_left = rw_nal_left - 32'd1;
      if (rw_nal_left == 32'd0) rw_in_nal = 1'b0;
    end else begin
      rw_len_acc = {rw_len_acc[23:0], b};
      if ({1'b0, rw_len_seen} + 3'd1 == rw_pfx) begin
        for (int k = 0; k < 4; k++)
          res[k] = '{(k == int'(SC_LAST_IDX)) ? SC_LAST_BYTE : SC_ZERO_BYTE,
                     1'b1, 1'b0, 1'b0};
        n = 4;
        rw_nal_left = rw_len_acc;
        rw_in_nal   = (rw_len_acc != 32'd0);
        rw_len_acc  = '0;
        rw_len_seen = '0;
      end else begin
        rw_len_seen = rw_len_seen + 2'd1;
      end
    end
    if (last) begin
      corrupt = rw_bad | rw_in_nal | (rw_len_seen != 2'd0);
      if (n == 0) begin
        res[0] = NO_REC;
        n = 1;
      end
      res[n-1].eos     = 1'b1;
      res[n-1].corrupt = corrupt;
      rw_in_nal   = 1'b0;
      rw_len_acc  = '0;
      rw_len_seen = '0;
      rw_nal_left = '0;
      rw_bad      = 1'b0;
    end
    if (keep)
      for (int i = 0; i < n; i++) annexb_due.push_back(res[i]);
  endtask

  // Offer one byte and hold it until taken. Entered and left just after a
  // rising edge, so in_valid gets a single assignment per edge.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit keep);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_byte           <= b;
    in_last_of_sample <= last;
    do @(posedge clk); while (in_stall);
    bytes_taken++;
    rewrite_byte(b, last, keep);
  endtask

  // Register write once everything owed has come out and the pipe has settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] val);
    in_valid <= 1'b0;
    while (annexb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AVCC_MODE) rw_mode = {2'b00, val[0]};
    else rw_pfx = val;
  endtask

  // Random sample: mostly well-formed NAL chains, some cut short, overrun or noise
  task automatic send_sample();
    logic [7:0]  sample_q [$];
    logic [31:0] len_word;
    int          nals;
    int          pick;
    int          tail;
    bit          legal;
    legal = (rw_mode == MODE_PASS) || lfb_legal(rw_pfx);
    tx_calm = ($urandom_range(0, 3) == 0);
    if (rw_mode == MODE_PASS || !legal) begin
      repeat ($urandom_range(1, 8)) sample_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 99);
      nals = (pick < 80) ? $urandom_range(1, 3) : $urandom_range(0, 2);
      repeat (nals) begin
        len_word = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(7, 40))
                                               : 32'($urandom_range(0, 6));
        for (int i = int'(rw_pfx) - 1; i >= 0; i--)
          sample_q.push_back(8'(len_word >> (8 * i)));
        repeat (int'(len_word)) sample_q.push_back(8'($urandom_range(0, 255)));
      end
      if (pick >= 80) begin
        tail = $urandom_range(0, 2);
        if (tail == 0 && rw_pfx != LFB_ONE) begin
          // length field cut short
          repeat ($urandom_range(1, int'(rw_pfx) - 1))
            sample_q.push_back(8'($urandom_range(0, 255)));
        end else if (tail != 2) begin
          // random length, up to four payload bytes behind it
          repeat (int'(rw_pfx)) sample_q.push_back(8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 4)) sample_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 8)) sample_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if (sample_q.size() == 0) sample_q.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < sample_q.size(); i++)
      send_byte(sample_q[i], i == sample_q.size() - 1, 1'b1);
    if (legal) fed_items += sample_q.size();
  endtask

  // Stimulus
  initial begin
    logic [2:0] mode_pick;
    logic [2:0] lfb_pick;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_AVCC_MODE;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_byte           <= 8'h00;
    in_last_of_sample <= 1'b0;
    rw_mode     = MODE_AVCC;
    rw_pfx      = LFB_RESET;
    rw_in_nal   = 1'b0;
    rw_len_acc  = '0;
    rw_len_seen = '0;
    rw_nal_left = '0;
    rw_bad      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (PLAN[r].kind == ROW_REG) begin
        write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
      end else begin
        send_byte(PLAN[r].data, PLAN[r].last, PLAN[r].chk == CHK_MODEL);
        if (PLAN[r].chk == CHK_ONE) annexb_due.push_back(PLAN[r].want);
      end
    end

    // Random phases, each under its own register setting
    while (fed_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        mode_pick = MODE_PASS;
        lfb_pick  = 3'($urandom_range(0, 7));
      end else begin
        mode_pick = MODE_AVCC;
        if ($urandom_range(0, 99) < 90) begin
          case ($urandom_range(0, 2))
            0:       lfb_pick = LFB_ONE;
            1:       lfb_pick = LFB_TWO;
            default: lfb_pick = LFB_FOUR;
          endcase
        end else begin
          do lfb_pick = 3'($urandom_range(0, 7)); while (lfb_legal(lfb_pick));
        end
      end
      write_reg(REG_AVCC_MODE, mode_pick);
      write_reg(REG_LENGTH_FIELD_BYTES, lfb_pick);
      repeat ($urandom_range(2, 6)) send_sample();
    end

    in_valid <= 1'b0;
    while (annexb_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (annexb_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", annexb_due.size()));
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls with quiet stretches, plus one long hold-off so the
  // block backs up and stalls its input while the sender keeps offering.
  initial begin
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!squeeze_done && bytes_taken >= SQUEEZE_AFTER) begin
        out_stall <= 1'b1;
        for (int c = 0; c < SQUEEZE_CYCLES; c++) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(5, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
        hold = pick_gap();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  // Result monitor: each accepted result transaction against the oldest expectation
  always @(posedge clk) begin
    out_rec_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (annexb_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, byte %h", out_byte));
      end else begin
        want = annexb_due.pop_front();
        check_field("out_byte", out_byte, want.data);
        check_field("byte_valid", 8'(out_byte_valid), 8'(want.byte_vld));
        check_field("end_of_sample", 8'(out_end_of_sample), 8'(want.eos));
        check_field("status", 8'(out_status), 8'(want.corrupt));
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lptsc_pkg.sv
hw/rtl/lptsc_parse.sv
hw/rtl/lptsc_burst.sv
hw/rtl/length_prefix_to_start_code_unit.sv
verif/length_prefix_to_start_code_unit_test.sv
